@@ rtl/core/swc_pkg.sv @@
`default_nettype none
package swc_pkg;

  localparam int MAX_LENGTH_DEF     = 4096;
  localparam int COEF_FRAC_BITS_DEF = 16;

  localparam int IDX_W      = 12;
  localparam int LEN_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TYPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMMETRIC   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH      = 2'd2;

  // phase divider: 32 quotient bits, a few per stage
  localparam int PH_W          = 32;
  localparam int REM_W         = LEN_W + 1;
  localparam int DIV_PER_STAGE = 4;
  localparam int DIV_STAGES    = PH_W / DIV_PER_STAGE;

  // cosine unit: Q30 values, six series steps of four stages each
  localparam int QF        = 30;
  localparam int COS_W     = 33;
  localparam int COS_STEPS = 6;
  localparam int COS_LAT   = COS_STEPS * 4 + 3;

  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
  localparam logic [30:0] ONE_Q30    = 31'd1073741824;
  localparam logic [29:0] HAM_A      = 30'd579820585;
  localparam logic [29:0] HAM_B      = 30'd493921239;
  localparam logic [29:0] BLK_A      = 30'd450971566;
  localparam logic [29:0] BLK_B      = 30'd536870912;
  localparam logic [29:0] BLK_C      = 30'd85899346;

  typedef enum logic [1:0] {
    WT_BARTLETT = 2'd0,
    WT_HANN     = 2'd1,
    WT_HAMMING  = 2'd2,
    WT_BLACKMAN = 2'd3
  } wtype_t;

  typedef struct packed {
    logic [29:0]      x;
    logic [COS_W-1:0] sum;
    logic             use_cos;
    logic             neg;
    logic [30:0]      val;
    logic [30:0]      aux;
  } swc_lane_t;

  typedef struct packed {
    logic oor;
    logic den_zero;
    logic bart;
    logic full;
    logic zero;
  } swc_flags_t;

endpackage
`default_nettype wire

@@ rtl/core/swc_cos.sv @@
`default_nettype none
module swc_cos (
  input  logic                       clk,
  input  logic                       en,
  input  logic [swc_pkg::PH_W-1:0]   ph,
  output logic [swc_pkg::COS_W-1:0]  cos_val
);
  import swc_pkg::*;

  localparam int NL = COS_STEPS * 4;

  logic [1:0]       quad;
  logic [29:0]      frac;
  logic             fold;
  logic [29:0]      rr_r;
  logic             use_cos_r;
  logic             neg_r;
  logic [63:0]      rad;
  logic [29:0]      x0;
  logic [30:0]      v0;
  swc_lane_t        lane_r   [0:NL];
  swc_lane_t        lane_nxt [0:NL];
  logic [COS_W-1:0] cos_val_r;

  // fold to an eighth of a turn; pick the series that the quadrant needs
  always_comb begin
    quad = ph[31:30];
    frac = ph[29:0];
    fold = frac > 30'h2000_0000;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rr_r      <= fold ? 30'(31'h4000_0000 - {1'b0, frac}) : frac;
      use_cos_r <= (quad[0] == fold);
      neg_r     <= quad[0] ^ quad[1];
    end
  end

  always_comb begin
    rad                 = 64'(rr_r) * 64'(TWO_PI_Q30) + 64'h8000_0000;
    x0                  = rad[61:32];
    v0                  = use_cos_r ? ONE_Q30 : {1'b0, x0};
    lane_nxt[0].x       = x0;
    lane_nxt[0].val     = v0;
    lane_nxt[0].aux     = v0;
    lane_nxt[0].sum     = {2'b00, v0};
    lane_nxt[0].use_cos = use_cos_r;
    lane_nxt[0].neg     = neg_r;
  end

  for (genvar k = 0; k < COS_STEPS; k++) begin : g_step
    localparam int DC = (2 * k + 1) * (2 * k + 2);
    localparam int DS = (2 * k + 2) * (2 * k + 3);
    localparam logic [31:0] MC = 32'((64'd1 << 32) / DC);
    localparam logic [31:0] MS = 32'((64'd1 << 32) / DS);
    localparam int B = 4 * k;

    swc_lane_t   a_nxt, b_nxt, c_nxt, d_nxt;
    logic [60:0] pa, pb;
    logic [62:0] pc;
    logic [31:0] mm;
    logic [7:0]  dd;
    logic [38:0] qd;
    logic [38:0] rm;
    logic [30:0] q1;
    logic        skip;

    always_comb begin
      // term * x, truncate
      a_nxt     = lane_r[B];
      pa        = 61'(lane_r[B].val) * 61'(lane_r[B].x);
      a_nxt.val = 31'(pa >> 30);
      // again * x, truncate
      b_nxt     = lane_r[B+1];
      pb        = 61'(lane_r[B+1].val) * 61'(lane_r[B+1].x);
      b_nxt.val = 31'(pb >> 30);
      // estimate quotient by reciprocal, may come out one low
      c_nxt     = lane_r[B+2];
      mm        = lane_r[B+2].use_cos ? MC : MS;
      pc        = 63'(lane_r[B+2].val) * 63'(mm);
      c_nxt.aux = lane_r[B+2].val;
      c_nxt.val = 31'(pc >> 32);
      // correct quotient and accumulate
      d_nxt     = lane_r[B+3];
      dd        = lane_r[B+3].use_cos ? 8'(DC) : 8'(DS);
      qd        = 39'(lane_r[B+3].val) * 39'(dd);
      rm        = 39'(lane_r[B+3].aux) - qd;
      q1        = lane_r[B+3].val + 31'(rm >= 39'(dd));
      skip      = !lane_r[B+3].use_cos && (k == COS_STEPS - 1);
      if (!skip) begin
        d_nxt.val = q1;
        if (k % 2 == 0) begin
          d_nxt.sum = lane_r[B+3].sum - {2'b00, q1};
        end else begin
          d_nxt.sum = lane_r[B+3].sum + {2'b00, q1};
        end
      end
    end

    assign lane_nxt[B+1] = a_nxt;
    assign lane_nxt[B+2] = b_nxt;
    assign lane_nxt[B+3] = c_nxt;
    assign lane_nxt[B+4] = d_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i <= NL; i++) begin
        lane_r[i] <= lane_nxt[i];
      end
      cos_val_r <= lane_r[NL].neg ? -lane_r[NL].sum : lane_r[NL].sum;
    end
  end

  assign cos_val = cos_val_r;

endmodule
`default_nettype wire

@@ rtl/core/spectral_window_coefficient_gen.sv @@
`default_nettype none
// channel   direction  handshake             payload
// in_       slave      in_tvalid/in_tready   sample_index
// out_      master     out_tvalid/out_tready coefficient, index_out_of_range
// cfg_      write      cfg_we                window_type, symmetric_form, window_length
//
// One word per cycle while out_ is not stalled; the path is the input stage,
// eight phase-divider stages (four quotient bits each), one phase stage,
// 27 cosine-series stages, three window-combine stages and the output register.
// rst_n (synchronous) clears valids and sets configuration to Hann, symmetric,
// length 1024. A stall on out_ freezes every stage together; no word is lost.
module spectral_window_coefficient_gen #(
  parameter int MAX_LENGTH     = swc_pkg::MAX_LENGTH_DEF,
  parameter int COEF_FRAC_BITS = swc_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [11:0] sample_index
  input  logic [((swc_pkg::IDX_W+7)/8)*8-1:0]   in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [COEF_FRAC_BITS:0] coefficient, [COEF_FRAC_BITS+1] index_out_of_range
  output logic [((COEF_FRAC_BITS+9)/8)*8-1:0]   out_tdata,
  input  logic                                  cfg_we,
  input  logic [swc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [swc_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import swc_pkg::*;

  localparam int CF     = COEF_FRAC_BITS;
  localparam int COEF_W = CF + 1;
  localparam int OUT_W  = ((CF + 9) / 8) * 8;
  localparam int SHIFT  = QF - CF;
  localparam int RND    = (1 << SHIFT) >> 1;
  localparam int BSH    = 31 - CF;
  localparam logic [COEF_W-1:0] COEF_ONE = {1'b1, {CF{1'b0}}};

  typedef struct packed {
    logic              oor;
    logic              special;
    logic [COEF_W-1:0] sval;
  } side_t;

  wtype_t           wtype_r;
  logic             sym_r;
  logic [LEN_W-1:0] wlen_r;

  logic en;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wtype_r <= WT_HANN;
      sym_r   <= 1'b1;
      wlen_r  <= LEN_W'(1024);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_TYPE: wtype_r <= wtype_t'(cfg_wdata[1:0]);
        CFG_SYMMETRIC:   sym_r   <= cfg_wdata[0];
        CFG_LENGTH:      wlen_r  <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  logic [LEN_W-1:0] len, den, twice, spread, numer, dvd;
  logic [IDX_W-1:0] idx;
  logic [REM_W-1:0] rem0;
  swc_flags_t       flg0;

  always_comb begin
    len    = (int'(wlen_r) > MAX_LENGTH) ? LEN_W'(MAX_LENGTH) : wlen_r;
    den    = sym_r ? len - LEN_W'(1) : len;
    idx    = in_tdata[IDX_W-1:0];
    twice  = {idx, 1'b0};
    spread = (twice >= den) ? twice - den : den - twice;
    numer  = den - spread;
    dvd    = (wtype_r == WT_BARTLETT) ? numer : {1'b0, idx};
    rem0   = (dvd >= den) ? '0 : {1'b0, dvd};
    flg0.oor      = {1'b0, idx} >= len;
    flg0.den_zero = den == '0;
    flg0.bart     = wtype_r == WT_BARTLETT;
    flg0.full     = spread == '0;
    flg0.zero     = spread >= den;
  end

  // phase divider
  logic             dv_r    [0:DIV_STAGES];
  logic [REM_W-1:0] rem_r   [0:DIV_STAGES];
  logic [PH_W-1:0]  quo_r   [0:DIV_STAGES];
  swc_flags_t       flg_r   [0:DIV_STAGES];
  logic [REM_W-1:0] rem_nxt [1:DIV_STAGES];
  logic [PH_W-1:0]  quo_nxt [1:DIV_STAGES];

  for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
    logic [REM_W-1:0] r, r2;
    logic [PH_W-1:0]  q;
    always_comb begin
      r  = rem_r[j-1];
      q  = quo_r[j-1];
      r2 = '0;
      for (int s = 0; s < DIV_PER_STAGE; s++) begin
        r2 = {r[REM_W-2:0], 1'b0};
        if (r2 >= {1'b0, den}) begin
          r = r2 - {1'b0, den};
          q = {q[PH_W-2:0], 1'b1};
        end else begin
          r = r2;
          q = {q[PH_W-2:0], 1'b0};
        end
      end
    end
    assign rem_nxt[j] = r;
    assign quo_nxt[j] = q;
  end

  // phase stage: Bartlett result and special cases settle here
  logic [PH_W-1:0]   ph;
  logic [COEF_W-1:0] bq;
  logic [COEF_W:0]   bsum;
  side_t             side0;

  always_comb begin
    ph            = quo_r[DIV_STAGES];
    bq            = COEF_W'(ph >> BSH);
    bsum          = {1'b0, bq} + (COEF_W + 1)'(1);
    side0.oor     = flg_r[DIV_STAGES].oor;
    side0.special = flg_r[DIV_STAGES].oor | flg_r[DIV_STAGES].den_zero |
                    flg_r[DIV_STAGES].bart;
    priority if (flg_r[DIV_STAGES].oor) begin
      side0.sval = '0;
    end else if (flg_r[DIV_STAGES].den_zero || flg_r[DIV_STAGES].full) begin
      side0.sval = COEF_ONE;
    end else if (flg_r[DIV_STAGES].zero) begin
      side0.sval = '0;
    end else begin
      side0.sval = bsum[COEF_W:1];
    end
  end

  logic            pv_r   [0:COS_LAT];
  side_t           side_r [0:COS_LAT];
  logic [PH_W-1:0] ph_r;
  logic [COS_W-1:0] c1, c2;

  swc_cos u_cos1 (
    .clk     (clk),
    .en      (en),
    .ph      (ph_r),
    .cos_val (c1)
  );

  swc_cos u_cos2 (
    .clk     (clk),
    .en      (en),
    .ph      ({ph_r[PH_W-2:0], 1'b0}),
    .cos_val (c2)
  );

  // window combine
  logic [34:0] hv, hvt, h;
  logic        w1_v_r, w2_v_r, w3_v_r;
  side_t       w1_side_r, w2_side_r, w3_side_r;
  logic [31:0] w1_m1_r, w1_m2_r;
  logic        w1_s1_r, w1_s2_r, w2_s1_r, w2_s2_r;
  logic [34:0] w1_h_r, w2_h_r;
  logic [29:0] a1;
  logic [63:0] pp1, pp2;
  logic [33:0] w2_p1_r, w2_p2_r;
  logic [35:0] sp1, sp2, wsum;
  logic [35:0] w3_w_r;

  always_comb begin
    hv  = {4'b0000, ONE_Q30} - {{2{c1[COS_W-1]}}, c1};
    hvt = hv + {34'd0, hv[34]};
    h   = {hvt[34], hvt[34:1]};
    a1  = (wtype_r == WT_HAMMING) ? HAM_B : BLK_B;
    pp1 = 64'(a1) * 64'(w1_m1_r) + 64'h2000_0000;
    pp2 = 64'(BLK_C) * 64'(w1_m2_r) + 64'h2000_0000;
    sp1 = w2_s1_r ? -{2'b00, w2_p1_r} : {2'b00, w2_p1_r};
    sp2 = w2_s2_r ? -{2'b00, w2_p2_r} : {2'b00, w2_p2_r};
    unique case (wtype_r)
      WT_HANN:     wsum = {w2_h_r[34], w2_h_r};
      WT_HAMMING:  wsum = 36'(HAM_A) - sp1;
      WT_BLACKMAN: wsum = 36'(BLK_A) - sp1 + sp2;
      default:     wsum = '0;
    endcase
  end

  // clamp, round, select
  logic [30:0]       u;
  logic [31:0]       ur;
  logic [COEF_W-1:0] coef;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_tdata_r;

  always_comb begin
    priority if (w3_w_r[35]) begin
      u = '0;
    end else if (w3_w_r > 36'(ONE_Q30)) begin
      u = ONE_Q30;
    end else begin
      u = w3_w_r[30:0];
    end
    ur   = (32'(u) + 32'(RND)) >> SHIFT;
    coef = w3_side_r.special ? w3_side_r.sval : COEF_W'(ur);
  end

  assign en         = !out_valid_r || out_tready;
  assign in_tready  = en;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  // valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= DIV_STAGES; j++) dv_r[j] <= 1'b0;
      for (int i = 0; i <= COS_LAT; i++) pv_r[i] <= 1'b0;
      w1_v_r      <= 1'b0;
      w2_v_r      <= 1'b0;
      w3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      dv_r[0] <= in_tvalid;
      for (int j = 1; j <= DIV_STAGES; j++) dv_r[j] <= dv_r[j-1];
      pv_r[0] <= dv_r[DIV_STAGES];
      for (int i = 1; i <= COS_LAT; i++) pv_r[i] <= pv_r[i-1];
      w1_v_r      <= pv_r[COS_LAT];
      w2_v_r      <= w1_v_r;
      w3_v_r      <= w2_v_r;
      out_valid_r <= w3_v_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= rem0;
      quo_r[0] <= '0;
      flg_r[0] <= flg0;
      for (int j = 1; j <= DIV_STAGES; j++) begin
        rem_r[j] <= rem_nxt[j];
        quo_r[j] <= quo_nxt[j];
        flg_r[j] <= flg_r[j-1];
      end
      ph_r      <= ph;
      side_r[0] <= side0;
      for (int i = 1; i <= COS_LAT; i++) side_r[i] <= side_r[i-1];
      w1_side_r <= side_r[COS_LAT];
      w1_s1_r   <= c1[COS_W-1];
      w1_s2_r   <= c2[COS_W-1];
      w1_m1_r   <= c1[COS_W-1] ? 32'(-c1) : 32'(c1);
      w1_m2_r   <= c2[COS_W-1] ? 32'(-c2) : 32'(c2);
      w1_h_r    <= h;
      w2_side_r <= w1_side_r;
      w2_s1_r   <= w1_s1_r;
      w2_s2_r   <= w1_s2_r;
      w2_p1_r   <= 34'(pp1 >> 30);
      w2_p2_r   <= 34'(pp2 >> 30);
      w2_h_r    <= w1_h_r;
      w3_side_r <= w2_side_r;
      w3_w_r    <= wsum;
      out_tdata_r <= OUT_W'({w3_side_r.oor, coef});
    end
  end

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[COEF_W]) |-> (out_tdata[COEF_W-1:0] == '0))
    else $error("out-of-range word carries a nonzero coefficient");

  a_coef_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[COEF_W-1:0] <= COEF_ONE))
    else $error("coefficient above 1.0");

  a_cos_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(c1) && $stable(c2) && $stable(pv_r[COS_LAT])))
    else $error("cosine pipeline moved during a stall");

endmodule
`default_nettype wire
